// ===== rtl/core/opd_pkg.sv =====
`timescale 1ns / 1ps

package opd_pkg;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_TAG    = 6'b000001,
    PH_NEW1   = 6'b000010,
    PH_NEW2   = 6'b000100,
    PH_SCALAR = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_INDET  = 6'b100000
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_BODY    = 3'd1,
    EV_INDET   = 3'd2,
    EV_NO_TAG  = 3'd3,
    EV_PARTIAL = 3'd4,
    EV_EARLY   = 3'd5
  } event_t;

  // new-format first length octet boundaries
  localparam logic [7:0] LEN_TWO_OCTET = 8'd192;
  localparam logic [7:0] LEN_PARTIAL   = 8'd224;
  localparam logic [7:0] LEN_FIVE      = 8'd255;

  // old-format length types
  localparam logic [1:0] OLD_LEN1  = 2'd0;
  localparam logic [1:0] OLD_LEN2  = 2'd1;
  localparam logic [1:0] OLD_LEN4  = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  len_left;
    logic [31:0] len_acc;
    logic [31:0] body_rem;
    logic [5:0]  tag;
    logic        new_fmt;
  } parse_state_t;

  typedef struct packed {
    event_t      ev;
    logic [5:0]  tag;
    logic        new_fmt;
    logic [31:0] pkt_len;
    logic        indet;
    logic [7:0]  body;
    logic        last;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_TAG, len_left: 3'd0, len_acc: 32'd0, body_rem: 32'd0,
    tag: 6'd0, new_fmt: 1'b0
  };

endpackage

// ===== rtl/core/opd_step.sv =====
`timescale 1ns / 1ps

module opd_step (
  input  opd_pkg::parse_state_t st,
  input  logic [7:0]            data_byte,
  input  logic                  end_marker,
  output opd_pkg::parse_state_t st_nxt,
  output logic                  res_valid,
  output opd_pkg::result_t      res
);
  import opd_pkg::*;

  logic [31:0] acc_new;
  logic [2:0]  left_dec;
  logic [31:0] rem_dec;

  assign left_dec = st.len_left - 3'd1;
  assign rem_dec  = st.body_rem - 32'd1;

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    res.ev    = EV_HEADER;
    acc_new   = st.len_acc;

    if (end_marker) begin
      // end of stream
      st_nxt.phase = PH_TAG;
      if (st.phase == PH_INDET) begin
        res_valid = 1'b1;
        res.ev    = EV_INDET;
        res.tag   = st.tag;
        res.indet = 1'b1;
      end else if (st.phase != PH_TAG && st.phase != '0 &&
                   $onehot(st.phase)) begin
        res_valid   = 1'b1;
        res.ev      = EV_EARLY;
        res.tag     = st.tag;
        res.new_fmt = st.new_fmt;
      end
    end else begin
      unique case (st.phase)
        PH_NEW1: begin
          if (data_byte < LEN_TWO_OCTET) begin
            acc_new   = {24'd0, data_byte};
            res_valid = 1'b1;
          end else if (data_byte < LEN_PARTIAL) begin
            st_nxt.len_acc = {19'd0, data_byte[4:0], 8'd0};
            st_nxt.phase   = PH_NEW2;
          end else if (data_byte < LEN_FIVE) begin
            res_valid    = 1'b1;
            res.ev       = EV_PARTIAL;
            res.tag      = st.tag;
            res.new_fmt  = st.new_fmt;
            st_nxt.phase = PH_TAG;
          end else begin
            st_nxt.len_acc  = 32'd0;
            st_nxt.len_left = 3'd4;
            st_nxt.phase    = PH_SCALAR;
          end
        end
        PH_NEW2: begin
          acc_new   = st.len_acc + {24'd0, data_byte} + {24'd0, LEN_TWO_OCTET};
          res_valid = 1'b1;
        end
        PH_SCALAR: begin
          acc_new         = {st.len_acc[23:0], data_byte};
          st_nxt.len_acc  = acc_new;
          st_nxt.len_left = left_dec;
          res_valid       = (left_dec == 3'd0);
        end
        PH_BODY: begin
          st_nxt.body_rem = rem_dec;
          res_valid       = 1'b1;
          res.ev          = EV_BODY;
          res.tag         = st.tag;
          res.new_fmt     = st.new_fmt;
          res.pkt_len     = st.len_acc;
          res.body        = data_byte;
          if (rem_dec == 32'd0) begin
            res.last     = 1'b1;
            st_nxt.phase = PH_TAG;
          end
        end
        PH_INDET: begin
          res_valid = 1'b1;
          res.ev    = EV_BODY;
          res.tag   = st.tag;
          res.indet = 1'b1;
          res.body  = data_byte;
        end
        default: begin
          // expect a tag byte
          st_nxt.phase = PH_TAG;
          if (!data_byte[7]) begin
            res_valid = 1'b1;
            res.ev    = EV_NO_TAG;
          end else begin
            st_nxt.len_acc  = 32'd0;
            st_nxt.body_rem = 32'd0;
            if (data_byte[6]) begin
              st_nxt.new_fmt = 1'b1;
              st_nxt.tag     = data_byte[5:0];
              st_nxt.phase   = PH_NEW1;
            end else begin
              st_nxt.new_fmt = 1'b0;
              st_nxt.tag     = {2'd0, data_byte[5:2]};
              case (data_byte[1:0])
                OLD_LEN1: begin
                  st_nxt.len_left = 3'd1;
                  st_nxt.phase    = PH_SCALAR;
                end
                OLD_LEN2: begin
                  st_nxt.len_left = 3'd2;
                  st_nxt.phase    = PH_SCALAR;
                end
                OLD_LEN4: begin
                  st_nxt.len_left = 3'd4;
                  st_nxt.phase    = PH_SCALAR;
                end
                default: begin
                  st_nxt.phase = PH_INDET;
                  res_valid    = 1'b1;
                  res.ev       = EV_HEADER;
                  res.tag      = {2'd0, data_byte[5:2]};
                  res.indet    = 1'b1;
                end
              endcase
            end
          end
        end
      endcase

      // header completion for sized lengths
      if (res_valid && (st.phase == PH_NEW1 || st.phase == PH_NEW2 ||
                        st.phase == PH_SCALAR) && res.ev == EV_HEADER) begin
        st_nxt.len_acc = acc_new;
        res.tag        = st.tag;
        res.new_fmt    = st.new_fmt;
        if (acc_new == 32'd0) begin
          res.last     = 1'b1;
          st_nxt.phase = PH_TAG;
        end else begin
          res.pkt_len     = acc_new;
          st_nxt.body_rem = acc_new;
          st_nxt.phase    = PH_BODY;
        end
      end
    end
  end

endmodule

// ===== rtl/core/openpgp_packet_header_deframer_core.sv =====
`timescale 1ns / 1ps

// OpenPGP packet header deframer: takes one stream byte (or an end-of-stream
// beat, in_tuser high) per cycle unless out_tready holds the output, and
// returns at most one event beat per input beat: a header once the length is
// complete, each body byte with tlast on the final one, an end-of-stream
// event for an indeterminate packet, or an error. A result beat is formed
// by the combinational parser update between the input register and the
// result register. After an error the parser waits for a new tag byte.
module openpgp_packet_header_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] end_marker
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] content_tag, [6] new_fmt,
                                  // [38:7] packet_length, [39] indeterminate,
                                  // [47:40] body_value
  output logic [2:0]  out_tuser,  // [2:0] event_res
  output logic        out_tlast   // last
);
  import opd_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_end_r;
  logic         advance;
  logic         fire;

  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         res_valid;
  result_t      res;

  logic         out_valid_r;
  result_t      out_r;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tuser;
    end
  end

  opd_step u_step (
    .st         (st_r),
    .data_byte  (in_byte_r),
    .end_marker (in_end_r),
    .st_nxt     (st_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_valid;
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.body, out_r.indet, out_r.pkt_len, out_r.new_fmt, out_r.tag};
  assign out_tuser  = out_r.ev;
  assign out_tlast  = out_r.last;

  // a stalled input register must hold a beat
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r)
    else $error("input stalled without a held beat");

  // a beat that produces a result is presented next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> out_tvalid)
    else $error("result lost");

  // last only on headers or body bytes
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_r.ev == EV_HEADER || out_r.ev == EV_BODY)
    else $error("last on an error event");

  // indeterminate packets are old format with no length
  a_indet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.indet |-> !out_r.new_fmt && out_r.pkt_len == 32'd0)
    else $error("indeterminate result with length or new format");

  // parser phase stays one-hot
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> $onehot(st_r.phase))
    else $error("parser phase lost one-hot code");

endmodule
